/* rtl/core/gfbi_pkg.sv */
// Shared types and constants for the grid field bilinear interpolator.
`default_nettype none

package gfbi_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;
  localparam int NCOMP        = 6;
  localparam int COMP_W       = 3;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int COORD_W      = 48;
  localparam int CNT_CFG_W    = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int MUL_A_W      = 50;
  localparam int MUL_B_W      = 17;
  localparam int PROD_W       = 68;
  localparam int IN_TDATA_W   = 112;
  localparam int OUT_TDATA_W  = NCOMP * DATA_W;

  localparam logic [MUL_B_W-1:0] WGT_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_HALF_EXTENT = 3'd4;

  localparam logic [CNT_CFG_W-1:0] RST_COLS_USED  = 7'd64;
  localparam logic [CNT_CFG_W-1:0] RST_ROWS_USED  = 7'd64;
  localparam logic [31:0]          RST_INV_CELL   = 32'h0001_0000;
  localparam logic [30:0]          RST_Z_HALF     = 31'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_XL,
    S_MUL_XH,
    S_MUL_ZL,
    S_MUL_ZH,
    S_LOCATE,
    S_RD00,
    S_RD01,
    S_RD10,
    S_RD11,
    S_MAC11,
    S_BLEND_B,
    S_BLEND_A,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/grid_field_bilinear_interpolator.sv */
// Top level: grid field bilinear interpolator with one shared multiplier.
// Write item: accepted while idle; the block stays ready and gives no result.
// Query item: accepted in idle, then the sequencer runs, and waits longer while a result
//   is still held: 4 coordinate products, a locate step, 7 steps for each of six
//   components and a result load, then a return to idle to accept the next item.
// Reset (rst_n low, synchronous): sequencer idle, result channel empty,
//   registers to defaults; grid contents are not cleared.
`default_nettype none

module grid_field_bilinear_interpolator
  import gfbi_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: grid_row[5:0], grid_col[11:6], component[14:12], sample_value[46:15],
  //        pos_x[78:47], pos_z[110:79], zero fill [111]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: operation[0]
  input  wire logic                   in_tuser,
  // result items
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: e_x[31:0], e_y[63:32], e_z[95:64], b_x[127:96], b_y[159:128], b_z[191:160]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS * NCOMP;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XI_W   = $clog2(MAX_COLS);
  localparam int ZI_W   = $clog2(MAX_ROWS);
  localparam int XN_W   = ($clog2(MAX_COLS + 1) > CNT_CFG_W) ? $clog2(MAX_COLS + 1) : CNT_CFG_W;
  localparam int ZN_W   = ($clog2(MAX_ROWS + 1) > CNT_CFG_W) ? $clog2(MAX_ROWS + 1) : CNT_CFG_W;

  // input fields
  logic [5:0]        in_row;
  logic [5:0]        in_col;
  logic [COMP_W-1:0] in_comp;
  logic [DATA_W-1:0] in_sample;
  logic [DATA_W-1:0] in_pos_x;
  logic [DATA_W-1:0] in_pos_z;

  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign in_comp   = in_tdata[14:12];
  assign in_sample = in_tdata[46:15];
  assign in_pos_x  = in_tdata[78:47];
  assign in_pos_z  = in_tdata[110:79];

  // configuration registers
  logic [CNT_CFG_W-1:0] cols_used_r;
  logic [CNT_CFG_W-1:0] rows_used_r;
  logic [31:0]          inv_x_r;
  logic [31:0]          inv_z_r;
  logic [30:0]          z_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_used_r <= RST_COLS_USED;
      rows_used_r <= RST_ROWS_USED;
      inv_x_r     <= RST_INV_CELL;
      inv_z_r     <= RST_INV_CELL;
      z_half_r    <= RST_Z_HALF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COLS_USED:     cols_used_r <= cfg_wdata[CNT_CFG_W-1:0];
        REG_ROWS_USED:     rows_used_r <= cfg_wdata[CNT_CFG_W-1:0];
        REG_INV_CELL_X:    inv_x_r     <= cfg_wdata;
        REG_INV_CELL_Z:    inv_z_r     <= cfg_wdata;
        REG_Z_HALF_EXTENT: z_half_r    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire, out_load, last_comp;

  logic [COMP_W-1:0] comp_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign last_comp = (comp_r == COMP_W'(NCOMP - 1));

  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_tuser == OP_QUERY) begin
          state_nxt = S_MUL_XL;
        end
      end
      S_MUL_XL:  state_nxt = S_MUL_XH;
      S_MUL_XH:  state_nxt = S_MUL_ZL;
      S_MUL_ZL:  state_nxt = S_MUL_ZH;
      S_MUL_ZH:  state_nxt = S_LOCATE;
      S_LOCATE:  state_nxt = S_RD00;
      S_RD00:    state_nxt = S_RD01;
      S_RD01:    state_nxt = S_RD10;
      S_RD10:    state_nxt = S_RD11;
      S_RD11:    state_nxt = S_MAC11;
      S_MAC11:   state_nxt = S_BLEND_B;
      S_BLEND_B: state_nxt = S_BLEND_A;
      S_BLEND_A: state_nxt = last_comp ? S_DONE : S_RD00;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // query operands and coordinates
  logic                 px_pos_r, pz_pos_r;
  logic [30:0]          px_mag_r;
  logic [31:0]          pz_mag_r;
  logic [COORD_W-1:0]   coord_x_r, coord_z_r;
  logic [XI_W-1:0]      x_lo_r, x_hi_r;
  logic [ZI_W-1:0]      z_lo_r, z_hi_r;
  logic [FRAC_W-1:0]    fx_r, fz_r;
  logic signed [48:0]   a_r;
  logic signed [PROD_W-1:0] acc_r;
  logic [DATA_W-1:0]    wres_r [NCOMP];
  logic [DATA_W-1:0]    out_r  [NCOMP];

  logic signed [32:0]   pz_sum;
  assign pz_sum = $signed({in_pos_z[31], in_pos_z}) + $signed({2'b00, z_half_r});

  // clamp the used counts and locate the cell on each axis
  logic [XN_W-1:0] ncx, x_lastn;
  logic [ZN_W-1:0] ncz, z_lastn;
  logic            x_at_end, z_at_end;

  always_comb begin
    if (cols_used_r == '0) begin
      ncx = XN_W'(1);
    end else if (XN_W'(cols_used_r) > XN_W'(MAX_COLS)) begin
      ncx = XN_W'(MAX_COLS);
    end else begin
      ncx = XN_W'(cols_used_r);
    end
    if (rows_used_r == '0) begin
      ncz = ZN_W'(1);
    end else if (ZN_W'(rows_used_r) > ZN_W'(MAX_ROWS)) begin
      ncz = ZN_W'(MAX_ROWS);
    end else begin
      ncz = ZN_W'(rows_used_r);
    end
    x_lastn  = ncx - XN_W'(1);
    z_lastn  = ncz - ZN_W'(1);
    x_at_end = (coord_x_r >= COORD_W'({x_lastn, {FRAC_W{1'b0}}}));
    z_at_end = (coord_z_r >= COORD_W'({z_lastn, {FRAC_W{1'b0}}}));
  end

  // weights
  logic [MUL_B_W-1:0] wx0, wx1, wz0, wz1;
  assign wx1 = {1'b0, fx_r};
  assign wz1 = {1'b0, fz_r};
  assign wx0 = WGT_ONE - wx1;
  assign wz0 = WGT_ONE - wz1;

  // grid memory
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] rd_data;
  logic [ZI_W-1:0]   rd_row;
  logic [XI_W-1:0]   rd_col;

  assign mem_we = in_fire && (in_tuser == OP_WRITE) && (32'(in_row) < MAX_ROWS)
                  && (32'(in_col) < MAX_COLS) && (32'(in_comp) < NCOMP);
  assign mem_waddr = (ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col))
                     * ADDR_W'(NCOMP) + ADDR_W'(in_comp);

  always_comb begin
    rd_row = z_lo_r;
    rd_col = x_lo_r;
    unique case (state_r)
      S_RD01: rd_col = x_hi_r;
      S_RD10: rd_row = z_hi_r;
      S_RD11: begin
        rd_row = z_hi_r;
        rd_col = x_hi_r;
      end
      default: ;
    endcase
  end

  assign mem_raddr = (ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col))
                     * ADDR_W'(NCOMP) + ADDR_W'(comp_r);

  gfbi_grid_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_grid_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_sample),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc_sum;
  logic signed [PROD_W-1:0]  rnd_sum;

  always_comb begin
    mul_a = {{(MUL_A_W - DATA_W){rd_data[DATA_W-1]}}, rd_data};
    mul_b = wx0;
    unique case (state_r)
      S_MUL_XL: begin
        mul_a = {{(MUL_A_W - 31){1'b0}}, px_mag_r};
        mul_b = {1'b0, inv_x_r[15:0]};
      end
      S_MUL_XH: begin
        mul_a = {{(MUL_A_W - 31){1'b0}}, px_mag_r};
        mul_b = {1'b0, inv_x_r[31:16]};
      end
      S_MUL_ZL: begin
        mul_a = {{(MUL_A_W - 32){1'b0}}, pz_mag_r};
        mul_b = {1'b0, inv_z_r[15:0]};
      end
      S_MUL_ZH: begin
        mul_a = {{(MUL_A_W - 32){1'b0}}, pz_mag_r};
        mul_b = {1'b0, inv_z_r[31:16]};
      end
      S_RD10:    mul_b = wx1;
      S_MAC11:   mul_b = wx1;
      S_BLEND_B: begin
        mul_a = {acc_r[48], acc_r[48:0]};
        mul_b = wz1;
      end
      S_BLEND_A: begin
        mul_a = {a_r[48], a_r};
        mul_b = wz0;
      end
      default: ;
    endcase
  end

  assign prod    = PROD_W'(mul_a * $signed({1'b0, mul_b}));
  assign acc_sum = acc_r + prod;
  assign rnd_sum = acc_sum + PROD_W'(64'sh8000_0000);

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        px_pos_r <= !in_pos_x[31] && (in_pos_x != '0);
        px_mag_r <= in_pos_x[30:0];
        pz_pos_r <= !pz_sum[32] && (pz_sum != '0);
        pz_mag_r <= pz_sum[31:0];
        comp_r   <= '0;
      end
      S_MUL_XL, S_MUL_ZL: acc_r <= prod;
      S_MUL_XH: coord_x_r <= prod[COORD_W-1:0] + COORD_W'(acc_r[47:16]);
      S_MUL_ZH: coord_z_r <= prod[COORD_W-1:0] + COORD_W'(acc_r[47:16]);
      S_LOCATE: begin
        if (!px_pos_r) begin
          x_lo_r <= '0;
          x_hi_r <= '0;
          fx_r   <= '0;
        end else if (x_at_end) begin
          x_lo_r <= x_lastn[XI_W-1:0];
          x_hi_r <= x_lastn[XI_W-1:0];
          fx_r   <= '0;
        end else begin
          x_lo_r <= coord_x_r[FRAC_W +: XI_W];
          x_hi_r <= coord_x_r[FRAC_W +: XI_W] + XI_W'(1);
          fx_r   <= coord_x_r[FRAC_W-1:0];
        end
        if (!pz_pos_r) begin
          z_lo_r <= '0;
          z_hi_r <= '0;
          fz_r   <= '0;
        end else if (z_at_end) begin
          z_lo_r <= z_lastn[ZI_W-1:0];
          z_hi_r <= z_lastn[ZI_W-1:0];
          fz_r   <= '0;
        end else begin
          z_lo_r <= coord_z_r[FRAC_W +: ZI_W];
          z_hi_r <= coord_z_r[FRAC_W +: ZI_W] + ZI_W'(1);
          fz_r   <= coord_z_r[FRAC_W-1:0];
        end
      end
      S_RD01:    acc_r <= prod;
      S_RD10:    a_r   <= acc_sum[48:0];
      S_RD11:    acc_r <= prod;
      S_MAC11:   acc_r <= acc_sum;
      S_BLEND_B: acc_r <= prod;
      S_BLEND_A: begin
        wres_r[comp_r] <= rnd_sum[63:32];
        comp_r         <= comp_r + COMP_W'(1);
      end
      default: ;
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= wres_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      out_tdata[i*DATA_W +: DATA_W] = out_r[i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gfbi_grid_mem.sv */
// Single-port-write, registered-read grid sample memory.
`default_nettype none

module gfbi_grid_mem
  import gfbi_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLS * NCOMP,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
